// ----- src/sis_pkg.sv -----
package sis_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Per-cell rewrite command, decided centrally and broadcast down the chain
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_MERGE  = 3'd2,
    ACT_ERASE  = 3'd3,
    ACT_SETLO  = 3'd4,
    ACT_SETHI  = 3'd5,
    ACT_SPLIT  = 3'd6
  } act_t;

  typedef struct packed {
    act_t        act;
    logic [33:0] lo;   // bounds carried 34 bits wide so that +1/-1 never wraps
    logic [33:0] hi;
  } cmd_t;

endpackage

// ----- src/sis_cell.sv -----
// One table slot. Compares its range against the key in parallel with the
// other slots and, on command, rewrites itself from its own or a neighbour's
// contents (shift up for a gap, shift down to close one).
module sis_cell (
  input  logic                clk,
  input  logic                used,
  input  logic                load,
  input  sis_pkg::cmd_t       cmd,
  input  logic                in_f,      // this slot is the first touched one
  input  logic                in_next,   // slot index just above the first
  input  logic                in_after,  // slot index above the first
  input  logic [4:0]          gap,       // set when the merge removes slots
  input  logic signed [33:0]  prev_lo,
  input  logic signed [33:0]  prev_hi,
  input  logic signed [33:0]  next_lo,
  input  logic signed [33:0]  next_hi,
  input  logic signed [33:0]  far_lo,
  input  logic signed [33:0]  far_hi,
  input  logic signed [33:0]  key_a,
  input  logic signed [33:0]  key_b,
  output logic signed [33:0]  lo,
  output logic signed [33:0]  hi,
  output logic                hi_below, // hi < key_a
  output logic                lo_le     // lo <= key_b
);

  logic signed [33:0] lo_next;
  logic signed [33:0] hi_next;

  assign hi_below = used && (hi < key_a);
  assign lo_le    = used && (lo <= key_b);

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    case (cmd.act)
      sis_pkg::ACT_INSERT: begin
        if (in_f) begin
          lo_next = cmd.lo;
          hi_next = cmd.hi;
        end else if (in_after) begin
          lo_next = prev_lo;
          hi_next = prev_hi;
        end
      end
      sis_pkg::ACT_MERGE: begin
        if (in_f) begin
          lo_next = cmd.lo;
          hi_next = cmd.hi;
        end else if (in_after && gap != 5'd0) begin
          lo_next = far_lo;
          hi_next = far_hi;
        end
      end
      sis_pkg::ACT_ERASE: begin
        if (in_f || in_after) begin
          lo_next = next_lo;
          hi_next = next_hi;
        end
      end
      sis_pkg::ACT_SETLO: if (in_f) lo_next = cmd.lo;
      sis_pkg::ACT_SETHI: if (in_f) hi_next = cmd.hi;
      sis_pkg::ACT_SPLIT: begin
        // lower half stays here, upper half lands in the slot above
        if (in_f) begin
          hi_next = cmd.lo;
        end else if (in_next) begin
          lo_next = cmd.hi;
          hi_next = prev_hi;
        end else if (in_after) begin
          lo_next = prev_lo;
          hi_next = prev_hi;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

endmodule

// ----- src/sorted_interval_set.sv -----
// After an input is accepted, the search, plan and rewrite states run in turn
// before the result is valid.
// One item at a time: s_tready is high only while idle, so a stalled result
// holds the input off.
// Reset: synchronous active-high rst empties the table and drops any result.
// Slot contents are not cleared; only slots below the fill count are read.
module sorted_interval_set #(
  parameter int MAX_RANGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // op[1:0], value_low[33:2], value_high[65:34], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // is_member, not_empty, table_full, changed,
                                // range_count[8:4], zero
);

  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int IW = $clog2(MAX_RANGES + 1);
  localparam int AW = $clog2(MAX_RANGES);

  typedef enum logic [2:0] {IDLE, SEARCH, PLAN, WRITE, OUT} state_t;

  state_t              state;
  logic [1:0]          op;
  logic signed [33:0]  va;
  logic signed [33:0]  vb;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  sis_pkg::cmd_t       cmd;
  logic [IW-1:0]       f_idx;
  logic [IW-1:0]       e_idx;
  logic [IW-1:0]       f_calc;
  logic [IW-1:0]       e_calc;
  logic                member;
  logic                full;
  logic                chg;
  logic signed [33:0]  ka;
  logic signed [33:0]  kb;

  sis_pkg::cmd_t       plan_cmd;
  logic                plan_member;
  logic                plan_full;
  logic                plan_chg;
  logic [CW-1:0]       plan_count;
  logic [AW-1:0]       f_at;
  logic [AW-1:0]       l_at;
  logic signed [33:0]  f_lo;
  logic signed [33:0]  f_hi;
  logic signed [33:0]  l_hi;

  logic signed [33:0]  lo [MAX_RANGES];
  logic signed [33:0]  hi [MAX_RANGES];
  logic [MAX_RANGES-1:0] hb;
  logic [MAX_RANGES-1:0] le;

  assign s_tready = (state == IDLE);

  // Search keys: insert looks for hi >= lo-1 and lo <= hi+1, others use x
  always_comb begin
    if (op == sis_pkg::OP_INSERT) begin
      ka = va - 34'sd1;
      kb = vb + 34'sd1;
    end else begin
      ka = va;
      kb = va;
    end
  end

  always_comb begin
    f_calc = IW'(0);
    for (int i = 0; i < MAX_RANGES; i++)
      if (hb[i]) f_calc = IW'(i + 1);
    e_calc = IW'(0);
    for (int i = 0; i < MAX_RANGES; i++)
      if (le[i]) e_calc = IW'(i + 1);
    if (e_calc < f_calc) e_calc = f_calc;
  end

  // first touched slot and last touched slot
  assign f_at = AW'(f_idx);
  assign l_at = AW'(e_idx - IW'(1));
  assign f_lo = lo[f_at];
  assign f_hi = hi[f_at];
  assign l_hi = hi[l_at];

  always_comb begin
    plan_cmd.act = sis_pkg::ACT_NONE;
    plan_cmd.lo  = va;
    plan_cmd.hi  = vb;
    plan_member  = 1'b0;
    plan_full    = 1'b0;
    plan_chg     = 1'b0;
    plan_count   = count;
    case (op)
      sis_pkg::OP_INSERT: if (vb >= va) begin
        if (e_idx == f_idx) begin
          if (IW'(count) >= IW'(MAX_RANGES)) plan_full = 1'b1;
          else begin
            plan_cmd.act = sis_pkg::ACT_INSERT;
            plan_chg     = 1'b1;
            plan_count   = count + CW'(1);
          end
        end else if (!(e_idx == f_idx + IW'(1) && f_lo <= va && f_hi >= vb)) begin
          plan_cmd.act = sis_pkg::ACT_MERGE;
          plan_cmd.lo  = (f_lo < va) ? f_lo : va;
          plan_cmd.hi  = (l_hi > vb) ? l_hi : vb;
          plan_chg     = 1'b1;
          plan_count   = count - CW'(e_idx - f_idx - IW'(1));
        end
      end
      sis_pkg::OP_REMOVE: begin
        if (f_idx < IW'(count) && f_lo <= va) begin
          if (f_lo == va && f_hi == va) begin
            plan_cmd.act = sis_pkg::ACT_ERASE;
            plan_chg     = 1'b1;
            plan_count   = count - CW'(1);
          end else if (f_lo == va) begin
            plan_cmd.act = sis_pkg::ACT_SETLO;
            plan_cmd.lo  = va + 34'sd1;
            plan_chg     = 1'b1;
          end else if (f_hi == va) begin
            plan_cmd.act = sis_pkg::ACT_SETHI;
            plan_cmd.hi  = va - 34'sd1;
            plan_chg     = 1'b1;
          end else if (IW'(count) >= IW'(MAX_RANGES)) begin
            plan_full = 1'b1;
          end else begin
            plan_cmd.act = sis_pkg::ACT_SPLIT;
            plan_cmd.lo  = va - 34'sd1;
            plan_cmd.hi  = va + 34'sd1;
            plan_chg     = 1'b1;
            plan_count   = count + CW'(1);
          end
        end
      end
      sis_pkg::OP_QUERY:
        plan_member = f_idx < IW'(count) && f_lo <= va;
      default: begin
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < MAX_RANGES; g++) begin : g_cell
      localparam int PI = (g == 0) ? 0 : g - 1;
      localparam int NI = (g == MAX_RANGES - 1) ? g : g + 1;
      logic [4:0] gap5;
      logic [IW:0] fi;
      logic signed [33:0] flo, fhi;
      always_comb begin
        fi  = {1'b0, IW'(g)} + {1'b0, e_idx} - {1'b0, f_idx} - (IW+1)'(1);
        flo = lo[g];
        fhi = hi[g];
        for (int j = 0; j < MAX_RANGES; j++)
          if (fi == (IW+1)'(j)) begin
            flo = lo[j];
            fhi = hi[j];
          end
        gap5 = (e_idx - f_idx > IW'(1)) ? 5'd1 : 5'd0;
      end
      sis_cell u_cell (
        .clk(clk),
        .used(IW'(g) < IW'(count)),
        .load(state == WRITE),
        .cmd(cmd),
        .in_f(IW'(g) == f_idx),
        .in_next(IW'(g) == f_idx + IW'(1)),
        .in_after(IW'(g) > f_idx),
        .gap(gap5),
        .prev_lo(lo[PI]), .prev_hi(hi[PI]),
        .next_lo(lo[NI]), .next_hi(hi[NI]),
        .far_lo(flo), .far_hi(fhi),
        .key_a(ka), .key_b(kb),
        .lo(lo[g]), .hi(hi[g]),
        .hi_below(hb[g]), .lo_le(le[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        IDLE: if (s_tvalid) begin
          op    <= s_tdata[1:0];
          va    <= 34'(signed'(s_tdata[33:2]));
          vb    <= 34'(signed'(s_tdata[65:34]));
          state <= SEARCH;
        end
        SEARCH: begin
          f_idx <= f_calc;
          e_idx <= e_calc;
          state <= PLAN;
        end
        PLAN: begin
          cmd        <= plan_cmd;
          member     <= plan_member;
          full       <= plan_full;
          chg        <= plan_chg;
          count_next <= plan_count;
          state      <= WRITE;
        end
        WRITE: begin
          count    <= count_next;
          state    <= OUT;
          m_tvalid <= 1'b1;
        end
        OUT: if (m_tready) begin
          m_tvalid <= 1'b0;
          state    <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_tdata = {7'd0, 5'(count), chg, full, (count != '0), member};

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("accept while result pending");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RANGES)) else $error("count above capacity");
  a_full_nochg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(full && chg)) else $error("full and changed together");

endmodule

// ----- sim/sorted_interval_set_tb.sv -----
`timescale 1ns / 1ps

module sorted_interval_set_tb;

  localparam int MAX_RANGES = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1200;

  typedef struct packed {
    logic       is_member;
    logic       not_empty;
    logic       table_full;
    logic       changed;
    logic [4:0] range_count;
  } status_t;

  typedef struct {
    sis_pkg::op_t op;
    logic [31:0]  lo;
    logic [31:0]  hi;
    bit           typed;
    status_t      want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  sorted_interval_set #(.MAX_RANGES(MAX_RANGES)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the range table, bounds widened so +1/-1 never wraps
  longint  set_lo[MAX_RANGES];
  longint  set_hi[MAX_RANGES];
  int      set_n;
  status_t pending_status[$];
  int      errors;
  int      cycles;
  bit      quiet_tail;
  bit      sink_hold;

  task automatic report(string what, logic [15:0] got, status_t want);
    $display("mismatch %s: got %b want %b", what, got[8:0], want);
    errors++;
  endtask

  function automatic int first_at_or_above(longint key);
    int i;
    i = 0;
    while (i < set_n && set_hi[i] < key) i++;
    return i;
  endfunction

  function automatic void shift_up(int at);
    for (int i = set_n; i > at; i--) begin
      set_lo[i] = set_lo[i-1];
      set_hi[i] = set_hi[i-1];
    end
    set_n++;
  endfunction

  function automatic void shift_down(int at, int n);
    for (int i = at; i + n < set_n; i++) begin
      set_lo[i] = set_lo[i+n];
      set_hi[i] = set_hi[i+n];
    end
    set_n -= n;
  endfunction

  function automatic status_t apply_op(sis_pkg::op_t op, logic [31:0] a_raw,
                                       logic [31:0] b_raw);
    status_t s;
    longint  a, b;
    int      f, e, k;
    s = '0;
    a = longint'($signed(a_raw));
    b = longint'($signed(b_raw));
    case (op)
      sis_pkg::OP_INSERT: begin
        if (b >= a) begin
          f = first_at_or_above(a - 1);
          e = f;
          while (e < set_n && set_lo[e] <= b + 1) e++;
          k = e - f;
          if (k == 0) begin
            if (set_n >= MAX_RANGES) s.table_full = 1'b1;
            else begin
              shift_up(f);
              set_lo[f] = a;
              set_hi[f] = b;
              s.changed = 1'b1;
            end
          end else if (!(k == 1 && set_lo[f] <= a && set_hi[f] >= b)) begin
            if (set_lo[f] < a) a = set_lo[f];
            if (set_hi[e-1] > b) b = set_hi[e-1];
            set_lo[f] = a;
            set_hi[f] = b;
            shift_down(f + 1, k - 1);
            s.changed = 1'b1;
          end
        end
      end
      sis_pkg::OP_REMOVE: begin
        f = first_at_or_above(a);
        if (f < set_n && set_lo[f] <= a) begin
          s.changed = 1'b1;
          if (set_lo[f] == a && set_hi[f] == a) shift_down(f, 1);
          else if (set_lo[f] == a) set_lo[f] = a + 1;
          else if (set_hi[f] == a) set_hi[f] = a - 1;
          else if (set_n >= MAX_RANGES) begin
            s.table_full = 1'b1;
            s.changed = 1'b0;
          end else begin
            shift_up(f + 1);
            set_lo[f+1] = a + 1;
            set_hi[f+1] = set_hi[f];
            set_hi[f] = a - 1;
          end
        end
      end
      sis_pkg::OP_QUERY: begin
        f = first_at_or_above(a);
        s.is_member = (f < set_n) && (set_lo[f] <= a);
      end
      default: ;
    endcase
    s.not_empty = set_n > 0;
    s.range_count = set_n[4:0];
    return s;
  endfunction

  task automatic send(sis_pkg::op_t op, logic [31:0] a, logic [31:0] b, bit typed,
                      status_t want);
    status_t s;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tdata  = {6'd0, b, a, op};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    s = apply_op(op, a, b);
    if (typed) begin
      if (s !== want) report("directed row", 16'(s), want);
      s = want;
    end
    pending_status = {pending_status, s};
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // receiver with random stall bursts
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (quiet_tail) m_tready <= 1'b1;
    else if (sink_hold) m_tready <= 1'b0;
    else m_tready <= $urandom_range(0, 4) != 0;
  end

  always @(negedge clk) begin
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      sink_hold = 1'b1;
      repeat ($urandom_range(1, 3)) @(negedge clk);
      sink_hold = 1'b0;
    end
  end

  always @(posedge clk) begin
    status_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_status.size() == 0) report("unexpected", m_tdata, '0);
      else begin
        want = pending_status.pop_front();
        if (m_tdata[0] !== want.is_member) report("is_member", m_tdata, want);
        if (m_tdata[1] !== want.not_empty) report("not_empty", m_tdata, want);
        if (m_tdata[2] !== want.table_full) report("table_full", m_tdata, want);
        if (m_tdata[3] !== want.changed) report("changed", m_tdata, want);
        if (m_tdata[8:4] !== want.range_count) report("range_count", m_tdata, want);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sorted_interval_set] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] near_value(int base);
    return 32'($urandom_range(0, 40) + base);
  endfunction

  localparam logic [31:0] MIN_V = 32'h8000_0000;
  localparam logic [31:0] MAX_V = 32'h7fff_ffff;

  initial begin
    row_t         rows[$];
    sis_pkg::op_t op;
    logic [31:0]  a, b;
    int           pick;
    errors = 0;
    cycles = 0;
    quiet_tail = 0;
    sink_hold = 0;
    set_n = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // op, lo, hi, typed, {member, not_empty, full, changed, count}
    rows = '{
      '{sis_pkg::OP_QUERY,  32'd0, 32'd0, 1, '{0, 0, 0, 0, 5'd0}},
      '{sis_pkg::OP_REMOVE, 32'd5, 32'd0, 1, '{0, 0, 0, 0, 5'd0}},
      '{sis_pkg::OP_INSERT, 32'd9, 32'd3, 1, '{0, 0, 0, 0, 5'd0}},
      '{sis_pkg::OP_INSERT, MIN_V, MIN_V, 1, '{0, 1, 0, 1, 5'd1}},
      '{sis_pkg::OP_INSERT, MAX_V, MAX_V, 1, '{0, 1, 0, 1, 5'd2}},
      '{sis_pkg::OP_QUERY,  MIN_V, 32'd0, 1, '{1, 1, 0, 0, 5'd2}},
      '{sis_pkg::OP_QUERY,  MAX_V, 32'd0, 1, '{1, 1, 0, 0, 5'd2}},
      '{sis_pkg::OP_INSERT, 32'd10, 32'd20, 0, '0},
      '{sis_pkg::OP_INSERT, 32'd12, 32'd15, 0, '0},   // already covered
      '{sis_pkg::OP_INSERT, 32'd21, 32'd25, 0, '0},   // touching, merges
      '{sis_pkg::OP_REMOVE, 32'd15, 32'd0, 0, '0},    // split
      '{sis_pkg::OP_REMOVE, 32'd10, 32'd0, 0, '0},    // shrink low
      '{sis_pkg::OP_REMOVE, 32'd25, 32'd0, 0, '0},    // shrink high
      '{sis_pkg::OP_REMOVE, MIN_V, 32'd0, 0, '0},     // erase
      '{sis_pkg::OP_REMOVE, 32'd100, 32'd0, 0, '0},   // absent
      '{sis_pkg::OP_NONE,   32'hffff_ffff, 32'hffff_ffff, 0, '0},
      '{sis_pkg::OP_INSERT, MIN_V, MAX_V, 0, '0},     // swallow everything
      '{sis_pkg::OP_QUERY,  32'hffff_ffff, 32'd0, 0, '0}
    };
    foreach (rows[i]) send(rows[i].op, rows[i].lo, rows[i].hi, rows[i].typed, rows[i].want);
    // remove zero from the full range, then insert the full range again
    send(sis_pkg::OP_REMOVE, 32'd0, 32'd0, 0, '0);
    for (int v = -1; v <= 1; v += 2) begin
      a = 32'(v);
      send(sis_pkg::OP_INSERT, MIN_V, MAX_V, 0, '0);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - 150) quiet_tail = 1;
      if (n % 200 == 100) begin
        // hold off until the block has answered everything
        while (pending_status.size() != 0) @(negedge clk);
      end
      if (n % 300 == 0) begin
        // collapse the table into a single range with a wide insert, then remove both edge values
        send(sis_pkg::OP_INSERT, MIN_V, MAX_V, 0, '0);
        send(sis_pkg::OP_REMOVE, MIN_V, 0, 0, '0);
        send(sis_pkg::OP_REMOVE, MAX_V, 0, 0, '0);
      end
      pick = $urandom_range(0, 99);
      op = pick < 45 ? sis_pkg::OP_INSERT : pick < 75 ? sis_pkg::OP_REMOVE :
           pick < 97 ? sis_pkg::OP_QUERY : sis_pkg::OP_NONE;
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom();
        b = $urandom();
      end else begin
        // small window keeps ranges dense so merges, splits and full table happen
        a = near_value(-20) ;
        b = a + 32'($urandom_range(0, 3)) - ($urandom_range(0, 9) == 0 ? 32'd2 : 32'd0);
        if ($urandom_range(0, 19) == 0) a = a ^ 32'h8000_0000;
      end
      if ($urandom_range(0, 40) == 0) a = $urandom_range(0, 1) ? MIN_V : MAX_V;
      send(op, a, b, 0, '0);
    end

    while (pending_status.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("[sorted_interval_set] OK");
    else $display("[sorted_interval_set] ERROR");
    $finish;
  end

endmodule
